/* hdl/slut_pkg.sv */
// Shared types and constants for the symbolic LUT dot-product engine.
// No dependencies; every other file of the block but slut_ram imports this package.
package slut_pkg;

  // Default table sizes
  localparam int NUM_SYMBOLS_DEF        = 512;
  localparam int NUM_WEIGHT_SYMBOLS_DEF = 256;
  localparam int NUM_OUT_CHANNELS_DEF   = 64;

  // Field widths
  localparam int SYM_W  = 9;
  localparam int WSYM_W = 8;
  localparam int CHAN_W = 6;

  // Stream widths
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Word kinds carried on s_tuser
  typedef enum logic [1:0] {
    OP_COMPUTE   = 2'd0,
    OP_LOAD_PROD = 2'd1,
    OP_LOAD_ADD  = 2'd2,
    OP_LOAD_BIAS = 2'd3
  } op_t;

  // Classified input word
  typedef struct packed {
    op_t               kind;
    logic [SYM_W-1:0]  act;
    logic [WSYM_W-1:0] wt;
    logic [CHAN_W-1:0] chan;
    logic              last;
    logic [SYM_W-1:0]  row;
    logic [SYM_W-1:0]  col;
    logic [SYM_W-1:0]  val;
    logic              rng_ok;  // lookup or load address lies inside its table
  } item_t;

endpackage

/* hdl/symbolic_lut_dot_product.sv */
// Symbolic LUT dot-product engine, top level.
// Input words carry a kind on s_tuser: compute, or a load into one of three
// tables (product, addition, bias). A load in range writes one table entry and
// gives no result. Compute words carry an activation / weight symbol pair; the
// product symbol starts a run or is folded into the accumulator through the
// addition table. On a compute word with s_tlast set, the bias table maps
// the accumulator and the word's channel to one result word on m_*.
// Throughput: one word per cycle while no result waits on m_tready; the
// addition-RAM output feeds straight back as the next lookup address, so the
// accumulator closes every cycle. A last word reaches m_tvalid through the
// product, addition and bias RAM stages behind the queue.
// Reset clears the queue, pipeline valids and run state; table contents are
// not cleared and must be loaded before they are looked up.
// While a result waits with m_tready low it holds on m_tdata and the pipeline freezes;
// the 4-word queue keeps taking words until it fills, then s_tready drops.
// Depends on slut_pkg, slut_front, slut_queue, slut_back, slut_ram.
module symbolic_lut_dot_product #(
  parameter int NUM_SYMBOLS        = slut_pkg::NUM_SYMBOLS_DEF,
  parameter int NUM_WEIGHT_SYMBOLS = slut_pkg::NUM_WEIGHT_SYMBOLS_DEF,
  parameter int NUM_OUT_CHANNELS   = slut_pkg::NUM_OUT_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // act_sym[8:0], wt_sym[16:9], out_chan[22:17], table_row[31:23],
  // table_col[40:32], table_value[49:41], zero fill [55:50]
  input  logic [slut_pkg::IN_DATA_W-1:0]  s_tdata,
  // op[1:0]
  input  logic [slut_pkg::IN_USER_W-1:0]  s_tuser,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_sym[8:0], out_chan_echo[14:9], zero fill [15]
  output logic [slut_pkg::OUT_DATA_W-1:0] m_tdata
);
  import slut_pkg::*;

  item_t             front_item;
  item_t             q_item;
  logic              q_valid;
  logic              q_pop;
  logic [SYM_W-1:0]  res_sym;
  logic [CHAN_W-1:0] res_chan;

  // Classify incoming words
  slut_front #(
    .NUM_SYMBOLS        (NUM_SYMBOLS),
    .NUM_WEIGHT_SYMBOLS (NUM_WEIGHT_SYMBOLS),
    .NUM_OUT_CHANNELS   (NUM_OUT_CHANNELS)
  ) u_front (
    .tdata (s_tdata),
    .tuser (s_tuser),
    .tlast (s_tlast),
    .item  (front_item)
  );

  // Decoupling queue
  slut_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (front_item),
    .out_valid (q_valid),
    .pop       (q_pop),
    .out_item  (q_item)
  );

  // Lookup pipeline
  slut_back #(
    .NUM_SYMBOLS        (NUM_SYMBOLS),
    .NUM_WEIGHT_SYMBOLS (NUM_WEIGHT_SYMBOLS),
    .NUM_OUT_CHANNELS   (NUM_OUT_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .pop       (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_sym   (res_sym),
    .out_chan  (res_chan)
  );

  assign m_tdata = {1'b0, res_chan, res_sym};

endmodule

/* hdl/slut_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module slut_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/slut_front.sv */
// Front end: unpacks an input word and classifies it, checking its table range.
// Depends on slut_pkg.
module slut_front #(
  parameter int NUM_SYMBOLS        = slut_pkg::NUM_SYMBOLS_DEF,
  parameter int NUM_WEIGHT_SYMBOLS = slut_pkg::NUM_WEIGHT_SYMBOLS_DEF,
  parameter int NUM_OUT_CHANNELS   = slut_pkg::NUM_OUT_CHANNELS_DEF
) (
  input  logic [slut_pkg::IN_DATA_W-1:0] tdata,
  input  logic [slut_pkg::IN_USER_W-1:0] tuser,
  input  logic                           tlast,
  output slut_pkg::item_t                item
);
  import slut_pkg::*;

  item_t it;

  // Field unpacking
  always_comb begin
    it.kind   = op_t'(tuser);
    it.act    = tdata[8:0];
    it.wt     = tdata[16:9];
    it.chan   = tdata[22:17];
    it.last   = tlast;
    it.row    = tdata[31:23];
    it.col    = tdata[40:32];
    it.val    = tdata[49:41];
    it.rng_ok = 1'b0;
    // Range check against the table this word addresses
    unique case (it.kind)
      OP_COMPUTE:   it.rng_ok = (32'(it.act) < NUM_SYMBOLS) &&
                                (32'(it.wt) < NUM_WEIGHT_SYMBOLS);
      OP_LOAD_PROD: it.rng_ok = (32'(it.row) < NUM_SYMBOLS) &&
                                (32'(it.col) < NUM_WEIGHT_SYMBOLS);
      OP_LOAD_ADD:  it.rng_ok = (32'(it.row) < NUM_SYMBOLS) &&
                                (32'(it.col) < NUM_SYMBOLS);
      OP_LOAD_BIAS: it.rng_ok = (32'(it.row) < NUM_SYMBOLS) &&
                                (32'(it.col) < NUM_OUT_CHANNELS);
      default:      it.rng_ok = 1'b0;
    endcase
  end

  assign item = it;

endmodule

/* hdl/slut_queue.sv */
// Short FIFO of classified words between front and back end.
// Depends on slut_pkg.
module slut_queue #(
  parameter int DEPTH = slut_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  slut_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            pop,
  output slut_pkg::item_t out_item
);
  import slut_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t         slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;
  logic          take;

  assign in_ready  = (count != (AW+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign take      = pop && out_valid;
  assign out_item  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (32'(rd_ptr) == DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(take);
    end
  end

endmodule

/* hdl/slut_back.sv */
// Back end: product, addition and bias lookups in three pipeline stages,
// with the running accumulator. Depends on slut_pkg and slut_ram.
module slut_back #(
  parameter int NUM_SYMBOLS        = slut_pkg::NUM_SYMBOLS_DEF,
  parameter int NUM_WEIGHT_SYMBOLS = slut_pkg::NUM_WEIGHT_SYMBOLS_DEF,
  parameter int NUM_OUT_CHANNELS   = slut_pkg::NUM_OUT_CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  slut_pkg::item_t             in_item,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [slut_pkg::SYM_W-1:0]  out_sym,
  output logic [slut_pkg::CHAN_W-1:0] out_chan
);
  import slut_pkg::*;

  localparam int RW = $clog2(NUM_SYMBOLS);
  localparam int WW = $clog2(NUM_WEIGHT_SYMBOLS);
  localparam int CW = (NUM_OUT_CHANNELS > 1) ? $clog2(NUM_OUT_CHANNELS) : 1;

  logic adv;
  logic take;

  // Stage registers
  logic              s1_valid;
  item_t             s1;
  logic              s2_valid;
  item_t             s2;
  logic              s3_valid;
  logic [CHAN_W-1:0] s3_chan;
  logic              s3_zero;

  // Accumulator state
  logic             run_started;
  logic             acc_sel;   // accumulator sits in the addition RAM output
  logic             add_zero;  // last addition lookup was out of range
  logic [SYM_W-1:0] acc_reg;
  logic [SYM_W-1:0] acc_cur;

  // RAM ports
  logic             prod_we, prod_re;
  logic [SYM_W-1:0] prod_dout;
  logic             add_we, add_re;
  logic [SYM_W-1:0] add_dout;
  logic             bias_we, bias_re;
  logic [SYM_W-1:0] bias_dout;

  logic [SYM_W-1:0] prod;
  logic             add_ok;
  logic             bias_ok;
  logic             s1_comp;

  // Whole pipeline moves when the result stage is free or drained
  assign adv  = !s3_valid || out_ready;
  assign take = adv && in_valid;
  assign pop  = take;

  // Stage 0: product lookup, product table loads
  assign prod_re = take && (in_item.kind == OP_COMPUTE);
  assign prod_we = take && (in_item.kind == OP_LOAD_PROD) && in_item.rng_ok;

  slut_ram #(
    .WIDTH (SYM_W),
    .DEPTH (2 ** (RW + WW))
  ) u_prod_ram (
    .clk   (clk),
    .we    (prod_we),
    .waddr ({RW'(in_item.row), WW'(in_item.col)}),
    .wdata (in_item.val),
    .re    (prod_re),
    .raddr ({RW'(in_item.act), WW'(in_item.wt)}),
    .rdata (prod_dout)
  );

  // Current accumulator value
  always_comb begin
    if (acc_sel) begin
      acc_cur = add_zero ? '0 : add_dout;
    end else begin
      acc_cur = acc_reg;
    end
  end

  // Stage 1: fold the product into the accumulator, addition table loads
  assign prod    = s1.rng_ok ? prod_dout : '0;
  assign s1_comp = adv && s1_valid && (s1.kind == OP_COMPUTE);
  assign add_re  = s1_comp && run_started;
  assign add_ok  = (32'(acc_cur) < NUM_SYMBOLS) && (32'(prod) < NUM_SYMBOLS);
  assign add_we  = adv && s1_valid && (s1.kind == OP_LOAD_ADD) && s1.rng_ok;

  slut_ram #(
    .WIDTH (SYM_W),
    .DEPTH (2 ** (RW + RW))
  ) u_add_ram (
    .clk   (clk),
    .we    (add_we),
    .waddr ({RW'(s1.row), RW'(s1.col)}),
    .wdata (s1.val),
    .re    (add_re),
    .raddr ({RW'(acc_cur), RW'(prod)}),
    .rdata (add_dout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      run_started <= 1'b0;
      acc_sel     <= 1'b0;
      add_zero    <= 1'b0;
      acc_reg     <= '0;
    end else if (s1_comp) begin
      if (run_started) begin
        acc_sel  <= 1'b1;
        add_zero <= !add_ok;
      end else begin
        acc_sel <= 1'b0;
        acc_reg <= prod;
      end
      run_started <= !s1.last;
    end
  end

  // Stage 2: bias lookup on the last pair, bias table loads
  assign bias_re = adv && s2_valid && (s2.kind == OP_COMPUTE) && s2.last;
  assign bias_we = adv && s2_valid && (s2.kind == OP_LOAD_BIAS) && s2.rng_ok;
  assign bias_ok = (32'(acc_cur) < NUM_SYMBOLS) && (32'(s2.chan) < NUM_OUT_CHANNELS);

  slut_ram #(
    .WIDTH (SYM_W),
    .DEPTH (2 ** (RW + CW))
  ) u_bias_ram (
    .clk   (clk),
    .we    (bias_we),
    .waddr ({RW'(s2.row), CW'(s2.col)}),
    .wdata (s2.val),
    .re    (bias_re),
    .raddr ({RW'(acc_cur), CW'(s2.chan)}),
    .rdata (bias_dout)
  );

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
      s2_valid <= s1_valid;
      s3_valid <= bias_re;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      s1      <= in_item;
      s2      <= s1;
      s3_chan <= s2.chan;
      s3_zero <= !bias_ok;
    end
  end

  // Stage 3: result word
  assign out_valid = s3_valid;
  assign out_sym   = s3_zero ? '0 : bias_dout;
  assign out_chan  = s3_chan;

endmodule

/* hdl/slut_checker.sv */
// Port-level checks for symbolic_lut_dot_product, attached by bind.
// Depends on slut_pkg.
module slut_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [slut_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic [slut_pkg::IN_USER_W-1:0]  s_tuser,
  input logic                            s_tlast,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [slut_pkg::OUT_DATA_W-1:0] m_tdata
);
  import slut_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // After reset the queue is empty and no result is pending
  a_reset_state: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("reset left queue full or result pending");

  // No result can reach the output straight after leaving reset
  a_min_latency: assert property (@(posedge clk)
    rst ##1 !rst |=> !m_tvalid ##1 !m_tvalid)
    else $error("result appeared faster than the pipeline allows");

endmodule

bind symbolic_lut_dot_product slut_checker u_slut_checker (.*);

/* dv/tb_top.sv */
// Self-checking testbench for symbolic_lut_dot_product: directed table, then
// random load/compute word sequences checked against an in-bench predictor.
// Depends on slut_pkg and the symbolic_lut_dot_product RTL.
`timescale 1ns / 100ps

module tb_top;
  import slut_pkg::*;

  localparam int NS = NUM_SYMBOLS_DEF;
  localparam int NW = NUM_WEIGHT_SYMBOLS_DEF;
  localparam int NC = NUM_OUT_CHANNELS_DEF;

  localparam int RANDOM_ITEMS   = 1150;
  localparam int DIR_ROWS       = 21;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AT_RESULT = 20;
  localparam int DRAIN_CYCLES   = 32;
  localparam int IDLE_LIMIT     = 2000;

  // One input word, fields in stream order
  typedef struct packed {
    op_t               op;
    logic [SYM_W-1:0]  act;
    logic [WSYM_W-1:0] wt;
    logic [CHAN_W-1:0] chan;
    logic              last;
    logic [SYM_W-1:0]  row;
    logic [SYM_W-1:0]  col;
    logic [SYM_W-1:0]  val;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [SYM_W-1:0]  sym;
  } result_t;

  // Directed row: word plus an optional hand-written expected symbol
  typedef struct packed {
    in_word_t         word;
    logic             fixed;
    logic [SYM_W-1:0] fsym;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [IN_USER_W-1:0] s_tuser = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Predictor state: tables, written marks, run accumulator
  logic [SYM_W-1:0] prod_lut [NS*NW];
  logic [SYM_W-1:0] add_lut  [NS*NS];
  logic [SYM_W-1:0] bias_lut [NS*NC];
  bit               prod_set [NS*NW];
  bit               add_set  [NS*NS];
  bit               bias_set [NS*NC];
  logic [SYM_W-1:0] run_acc  = '0;
  bit               run_open = 1'b0;

  result_t pending_results [$];
  int      err_count  = 0;
  int      rx_count   = 0;
  int      word_count = 0;
  bit      burst      = 1'b0;

  dir_row_t directed [DIR_ROWS] = '{
    // single-word run, zero corner
    '{'{OP_LOAD_PROD, 9'd0, 8'd0, 6'd0, 1'b0, 9'd0, 9'd0, 9'd5}, 1'b0, 9'd0},
    '{'{OP_LOAD_BIAS, 9'd0, 8'd0, 6'd0, 1'b0, 9'd5, 9'd0, 9'd7}, 1'b0, 9'd0},
    '{'{OP_COMPUTE, 9'd0, 8'd0, 6'd0, 1'b1, 9'd0, 9'd0, 9'd0}, 1'b1, 9'd7},
    // top corner of every field
    '{'{OP_LOAD_PROD, 9'd0, 8'd0, 6'd0, 1'b0, 9'd511, 9'd255, 9'd511}, 1'b0, 9'd0},
    '{'{OP_LOAD_BIAS, 9'd0, 8'd0, 6'd0, 1'b0, 9'd511, 9'd63, 9'd341}, 1'b0, 9'd0},
    '{'{OP_COMPUTE, 9'd511, 8'd255, 6'd63, 1'b1, 9'd511, 9'd511, 9'd511}, 1'b1, 9'd341},
    // out-of-range loads must not alias onto column 0
    '{'{OP_LOAD_PROD, 9'd0, 8'd0, 6'd0, 1'b0, 9'd0, 9'd256, 9'd9}, 1'b0, 9'd0},
    '{'{OP_LOAD_BIAS, 9'd0, 8'd0, 6'd0, 1'b0, 9'd5, 9'd64, 9'd99}, 1'b0, 9'd0},
    '{'{OP_COMPUTE, 9'd0, 8'd0, 6'd0, 1'b1, 9'd0, 9'd0, 9'd0}, 1'b1, 9'd7},
    // two-word run with a load in the middle
    '{'{OP_LOAD_BIAS, 9'd0, 8'd0, 6'd0, 1'b0, 9'd3, 9'd1, 9'd200}, 1'b0, 9'd0},
    '{'{OP_COMPUTE, 9'd0, 8'd0, 6'd1, 1'b0, 9'd0, 9'd0, 9'd0}, 1'b0, 9'd0},
    '{'{OP_LOAD_ADD, 9'd0, 8'd0, 6'd0, 1'b0, 9'd5, 9'd511, 9'd3}, 1'b0, 9'd0},
    '{'{OP_COMPUTE, 9'd511, 8'd255, 6'd1, 1'b1, 9'd0, 9'd0, 9'd0}, 1'b1, 9'd200},
    // three-word run, addition entry written right before its lookup
    '{'{OP_COMPUTE, 9'd0, 8'd0, 6'd2, 1'b0, 9'd0, 9'd0, 9'd0}, 1'b0, 9'd0},
    '{'{OP_COMPUTE, 9'd511, 8'd255, 6'd2, 1'b0, 9'd0, 9'd0, 9'd0}, 1'b0, 9'd0},
    '{'{OP_LOAD_ADD, 9'd0, 8'd0, 6'd0, 1'b0, 9'd3, 9'd5, 9'd5}, 1'b0, 9'd0},
    '{'{OP_COMPUTE, 9'd0, 8'd0, 6'd0, 1'b1, 9'd0, 9'd0, 9'd0}, 1'b1, 9'd7},
    // overwrite a product entry
    '{'{OP_LOAD_PROD, 9'd0, 8'd0, 6'd0, 1'b0, 9'd0, 9'd0, 9'd511}, 1'b0, 9'd0},
    '{'{OP_COMPUTE, 9'd0, 8'd0, 6'd63, 1'b1, 9'd0, 9'd0, 9'd0}, 1'b1, 9'd341},
    // loads with compute fields and tlast set give nothing
    '{'{OP_LOAD_ADD, 9'd511, 8'd255, 6'd63, 1'b1, 9'd511, 9'd511, 9'd0}, 1'b0, 9'd0},
    '{'{OP_LOAD_BIAS, 9'd0, 8'd0, 6'd0, 1'b0, 9'd0, 9'd0, 9'd0}, 1'b0, 9'd0}
  };

  symbolic_lut_dot_product DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tb_top: mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Symbol values: mostly a small pool so table entries get reused
  function automatic logic [SYM_W-1:0] pick_sym();
    if ($urandom_range(0, 3) != 0) return SYM_W'($urandom_range(0, 15));
    return SYM_W'($urandom_range(0, NS - 1));
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.op   = op_t'($urandom_range(0, 3));
    w.act  = SYM_W'($urandom_range(0, 511));
    w.wt   = WSYM_W'($urandom_range(0, 255));
    w.chan = CHAN_W'($urandom_range(0, 63));
    w.last = 1'($urandom_range(0, 1));
    w.row  = SYM_W'($urandom_range(0, 511));
    w.col  = SYM_W'($urandom_range(0, 511));
    w.val  = SYM_W'($urandom_range(0, 511));
    return w;
  endfunction

  // Dot-product predictor: applies one accepted word to the table/run state
  task automatic dot_predict(input in_word_t w, output bit emits,
                             output logic [SYM_W-1:0] sym, output bit applied);
    logic [SYM_W-1:0] p;
    int idx;
    emits   = 1'b0;
    sym     = '0;
    applied = 1'b1;
    case (w.op)
      OP_LOAD_PROD: begin
        if (w.row < NS && w.col < NW) begin
          idx = int'(w.row) * NW + int'(w.col);
          prod_lut[idx] = w.val;
          prod_set[idx] = 1'b1;
        end else begin
          applied = 1'b0;
        end
      end
      OP_LOAD_ADD: begin
        if (w.row < NS && w.col < NS) begin
          idx = int'(w.row) * NS + int'(w.col);
          add_lut[idx] = w.val;
          add_set[idx] = 1'b1;
        end else begin
          applied = 1'b0;
        end
      end
      OP_LOAD_BIAS: begin
        if (w.row < NS && w.col < NC) begin
          idx = int'(w.row) * NC + int'(w.col);
          bias_lut[idx] = w.val;
          bias_set[idx] = 1'b1;
        end else begin
          applied = 1'b0;
        end
      end
      default: begin
        p = prod_lut[int'(w.act) * NW + int'(w.wt)];
        if (!run_open) begin
          run_acc  = p;
          run_open = 1'b1;
        end else begin
          run_acc = add_lut[int'(run_acc) * NS + int'(p)];
        end
        if (w.last) begin
          sym      = bias_lut[int'(run_acc) * NC + int'(w.chan)];
          run_open = 1'b0;
          emits    = 1'b1;
        end
      end
    endcase
  endtask

  // Offer one word, wait for the handshake, then predict
  task automatic send_word(input in_word_t w, input bit fixed, input logic [SYM_W-1:0] fsym);
    int gap;
    bit emits;
    bit applied;
    logic [SYM_W-1:0] sym;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, w.val, w.col, w.row, w.chan, w.wt, w.act};
    s_tuser  <= w.op;
    s_tlast  <= w.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    dot_predict(w, emits, sym, applied);
    if (fixed) pending_results.push_back('{chan: w.chan, sym: fsym});
    else if (emits) pending_results.push_back('{chan: w.chan, sym: sym});
    if (applied) word_count++;
  endtask

  function automatic in_word_t load_word(input op_t op, input int row, input int col);
    in_word_t w;
    w     = rand_word();
    w.op  = op;
    w.row = SYM_W'(row);
    w.col = SYM_W'(col);
    w.val = pick_sym();
    return w;
  endfunction

  // One compute word, preceded by whatever loads its lookups need
  task automatic run_compute();
    in_word_t w;
    logic [SYM_W-1:0] p;
    logic [SYM_W-1:0] nacc;
    int idx;
    w      = rand_word();
    w.op   = OP_COMPUTE;
    w.last = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 3) != 0) begin
      w.act = SYM_W'($urandom_range(0, 15));
      w.wt  = WSYM_W'($urandom_range(0, 15));
    end
    if ($urandom_range(0, 3) != 0) w.chan = CHAN_W'($urandom_range(0, 3));
    idx = int'(w.act) * NW + int'(w.wt);
    if (!prod_set[idx] || $urandom_range(0, 9) == 0)
      send_word(load_word(OP_LOAD_PROD, int'(w.act), int'(w.wt)), 1'b0, '0);
    p    = prod_lut[idx];
    nacc = p;
    if (run_open) begin
      idx = int'(run_acc) * NS + int'(p);
      if (!add_set[idx] || $urandom_range(0, 9) == 0)
        send_word(load_word(OP_LOAD_ADD, int'(run_acc), int'(p)), 1'b0, '0);
      nacc = add_lut[idx];
    end
    if (w.last) begin
      idx = int'(nacc) * NC + int'(w.chan);
      if (!bias_set[idx] || $urandom_range(0, 9) == 0)
        send_word(load_word(OP_LOAD_BIAS, int'(nacc), int'(w.chan)), 1'b0, '0);
    end
    send_word(w, 1'b0, '0);
  endtask

  // Stimulus and end of run
  initial begin
    in_word_t w;
    bit paused;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(directed[i].word, directed[i].fixed, directed[i].fsym);
    end
    word_count = 0;
    while (word_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 49) == 0) burst = ($urandom_range(0, 2) == 0);
      // quiet point: let every pending result drain
      if (!paused && word_count >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 15) begin
        w    = rand_word();
        w.op = op_t'($urandom_range(1, 3));
        send_word(w, 1'b0, '0);
      end else begin
        run_compute();
      end
    end
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Result side: check each word, drive m_tready with random stalls
  initial begin
    int stall_left;
    bit hold_done;
    bit sink_burst;
    result_t want;
    stall_left = 0;
    hold_done  = 1'b0;
    sink_burst = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with none pending", int'(m_tdata[SYM_W-1:0]), 0);
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[SYM_W-1:0] != want.sym)
            report_mismatch("out_sym", int'(m_tdata[SYM_W-1:0]), int'(want.sym));
          if (m_tdata[SYM_W+CHAN_W-1:SYM_W] != want.chan)
            report_mismatch("out_chan_echo", int'(m_tdata[SYM_W+CHAN_W-1:SYM_W]),
                            int'(want.chan));
        end
        rx_count++;
        // long hold-off so the queue fills and s_tready drops
        if (!hold_done && rx_count == HOLD_AT_RESULT) begin
          hold_done  = 1'b1;
          stall_left = HOLD_CYCLES;
        end
      end
      if ($urandom_range(0, 99) == 0) sink_burst = ($urandom_range(0, 2) == 0);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!sink_burst && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: cycles with no word moving on either side
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

endmodule

/* symbolic_lut_dot_product.f */
hdl/slut_pkg.sv
hdl/slut_ram.sv
hdl/slut_front.sv
hdl/slut_queue.sv
hdl/slut_back.sv
hdl/symbolic_lut_dot_product.sv
hdl/slut_checker.sv
dv/tb_top.sv
